// ----- sv/rtmg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmg_pkg
// Shared types and constants of the rectangle triangle mesh generator.
// ----------------------------------------------------------------------------
package rtmg_pkg;

    // largest quad counts along x and y
    localparam int unsigned MAX_COLS = 1024;
    localparam int unsigned MAX_ROWS = 1024;

    // field widths
    localparam int CNT_W   = 11;
    localparam int NUM_W   = 22;
    localparam int COORD_W = 32;

    // result kinds
    localparam logic [1:0] KIND_GRID = 2'd0;
    localparam logic [1:0] KIND_MID  = 2'd1;
    localparam logic [1:0] KIND_TRI  = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    // diagonal modes
    localparam logic [2:0] DIAG_LEFT  = 3'd0;
    localparam logic [2:0] DIAG_RIGHT = 3'd1;
    localparam logic [2:0] DIAG_RL    = 3'd2;
    localparam logic [2:0] DIAG_LR    = 3'd3;
    localparam logic [2:0] DIAG_CROSS = 3'd4;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_COLS      = 3'd0,
        REG_ROWS      = 3'd1,
        REG_DIAG      = 3'd2,
        REG_X_START   = 3'd3,
        REG_Y_START   = 3'd4,
        REG_X_SPACING = 3'd5,
        REG_Y_SPACING = 3'd6
    } reg_idx_t;

    // pass phases
    typedef enum logic [1:0] {
        PH_GRID = 2'd0,
        PH_MID  = 2'd1,
        PH_TRI  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    // configuration as seen by the datapath (counts already clamped)
    typedef struct packed {
        logic [CNT_W-1:0]          cols;
        logic [CNT_W-1:0]          rows;
        logic [2:0]                diag_mode;
        logic signed [COORD_W-1:0] x_start;
        logic signed [COORD_W-1:0] y_start;
        logic signed [COORD_W-1:0] x_spacing;
        logic signed [COORD_W-1:0] y_spacing;
    } cfg_t;

    // one sequenced item, handed from the sequencer to the geometry stage
    typedef struct packed {
        logic [1:0]       kind;
        logic [NUM_W-1:0] item_number;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic [1:0]       sub;
        logic [NUM_W-1:0] row_base;
        logic             last;
    } seq_item_t;

    // one finished result beat
    typedef struct packed {
        logic [1:0]                kind;
        logic [NUM_W-1:0]          item_number;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic [NUM_W-1:0]          corner_a;
        logic [NUM_W-1:0]          corner_b;
        logic [NUM_W-1:0]          corner_c;
        logic                      last;
    } out_item_t;

endpackage

// ----- sv/rtmg_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmg_seq
// Pass sequencer: walks grid vertices, midpoints and triangles, one item per
// accepted request, and registers the item for the geometry stage.
// ----------------------------------------------------------------------------
module rtmg_seq
    import rtmg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      req_valid,
    input  logic      req_restart,
    input  logic      stage_advance,
    output logic      item_valid,
    output seq_item_t item
);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [1:0]       sub_reg, sub_next;
    logic [NUM_W-1:0] vcnt_reg, vcnt_next;
    logic [NUM_W-1:0] ccnt_reg, ccnt_next;
    logic [NUM_W-1:0] rbase_reg, rbase_next;
    logic             item_valid_reg;
    seq_item_t        item_reg, item_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_GRID;
            col_reg   <= '0;
            row_reg   <= '0;
            sub_reg   <= '0;
            vcnt_reg  <= '0;
            ccnt_reg  <= '0;
            rbase_reg <= '0;
        end else if (req_valid) begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            sub_reg   <= sub_next;
            vcnt_reg  <= vcnt_next;
            ccnt_reg  <= ccnt_next;
            rbase_reg <= rbase_next;
        end
    end

    // next state and the item for this request
    always_comb begin
        phase_t           p;
        logic [CNT_W:0]   c;
        logic [CNT_W:0]   r;
        logic [2:0]       s;
        logic [NUM_W-1:0] vc;
        logic [NUM_W-1:0] cc;
        logic [NUM_W-1:0] rb;
        logic [CNT_W:0]   cmax;
        logic [CNT_W:0]   rmax;
        logic [2:0]       ntri;
        logic             crossed;
        logic             emitted;

        p       = phase_reg;
        c       = {1'b0, col_reg};
        r       = {1'b0, row_reg};
        s       = {1'b0, sub_reg};
        vc      = vcnt_reg;
        cc      = ccnt_reg;
        rb      = rbase_reg;
        cmax    = {1'b0, cfg.cols};
        rmax    = {1'b0, cfg.rows};
        crossed = (cfg.diag_mode == DIAG_CROSS);
        ntri    = crossed ? 3'd4 : 3'd2;
        emitted = 1'b0;

        item_next             = '0;
        item_next.kind        = KIND_DONE;

        // restart clears the whole pass
        if (req_restart) begin
            p  = PH_GRID;
            c  = '0;
            r  = '0;
            s  = '0;
            rb = '0;
            vc = '0;
            cc = '0;
        end

        // grid vertices, row-major
        if (p == PH_GRID) begin
            if (c > cmax) begin
                c = '0;
                r = r + 1'b1;
            end
            if (r > rmax) begin
                p  = crossed ? PH_MID : PH_TRI;
                c  = '0;
                r  = '0;
                s  = '0;
                rb = '0;
            end else begin
                emitted               = 1'b1;
                item_next.kind        = KIND_GRID;
                item_next.item_number = vc;
                item_next.col         = c[CNT_W-1:0];
                item_next.row         = r[CNT_W-1:0];
                vc                    = vc + 1'b1;
                c                     = c + 1'b1;
                if (c > cmax) begin
                    c = '0;
                    r = r + 1'b1;
                end
            end
        end

        // quad midpoints in crossed mode
        if (!emitted && p == PH_MID) begin
            if (!crossed) begin
                p  = PH_TRI;
                c  = '0;
                r  = '0;
                s  = '0;
                rb = '0;
            end else begin
                if (c >= cmax) begin
                    c = '0;
                    r = r + 1'b1;
                end
                if (r >= rmax) begin
                    p  = PH_TRI;
                    c  = '0;
                    r  = '0;
                    s  = '0;
                    rb = '0;
                end else begin
                    emitted               = 1'b1;
                    item_next.kind        = KIND_MID;
                    item_next.item_number = vc;
                    item_next.col         = c[CNT_W-1:0];
                    item_next.row         = r[CNT_W-1:0];
                    vc                    = vc + 1'b1;
                    c                     = c + 1'b1;
                    if (c >= cmax) begin
                        c = '0;
                        r = r + 1'b1;
                    end
                end
            end
        end

        // triangles of each quad
        if (!emitted && p == PH_TRI) begin
            if (s >= ntri) begin
                s = '0;
                c = c + 1'b1;
            end
            if (c >= cmax) begin
                c  = '0;
                r  = r + 1'b1;
                rb = rb + NUM_W'(cmax) + 1'b1;
            end
            if (r >= rmax) begin
                p = PH_DONE;
            end else begin
                emitted               = 1'b1;
                item_next.kind        = KIND_TRI;
                item_next.item_number = cc;
                item_next.col         = c[CNT_W-1:0];
                item_next.row         = r[CNT_W-1:0];
                item_next.sub         = s[1:0];
                item_next.row_base    = rb;
                cc                    = cc + 1'b1;
                s                     = s + 1'b1;
                if (s >= ntri) begin
                    s = '0;
                    c = c + 1'b1;
                    if (c >= cmax) begin
                        c  = '0;
                        r  = r + 1'b1;
                        rb = rb + NUM_W'(cmax) + 1'b1;
                        if (r >= rmax) begin
                            p              = PH_DONE;
                            item_next.last = 1'b1;
                        end
                    end
                end
            end
        end

        phase_next = p;
        col_next   = c[CNT_W-1:0];
        row_next   = r[CNT_W-1:0];
        sub_next   = s[1:0];
        vcnt_next  = vc;
        ccnt_next  = cc;
        rbase_next = rb;
    end

    // item register toward the geometry stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (stage_advance) begin
            item_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_valid) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// ----- sv/rtmg_geom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmg_geom
// Geometry stage: vertex coordinates and triangle corner numbers for one
// sequenced item.
// ----------------------------------------------------------------------------
module rtmg_geom
    import rtmg_pkg::*;
(
    input  cfg_t      cfg,
    input  seq_item_t item,
    output out_item_t result
);

    localparam int MUL_W  = CNT_W + 2;
    localparam int PROD_W = MUL_W + COORD_W;
    localparam int SUM_W  = PROD_W + 1;

    // start + half-step multiple, halved with floor, saturated to 32 bits
    function automatic logic signed [COORD_W-1:0] coord(
        input logic signed [COORD_W-1:0] start,
        input logic signed [COORD_W-1:0] spacing,
        input logic [CNT_W:0]            steps
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [SUM_W-1:0]  sum;
        logic signed [PROD_W-1:0] half;
        logic                     fits;
        prod = $signed({1'b0, steps}) * spacing;
        sum  = $signed({start, 1'b0}) + SUM_W'(prod);
        half = sum[SUM_W-1:1];
        fits = (half[PROD_W-1:COORD_W-1] == '0) || (&half[PROD_W-1:COORD_W-1]);
        if (fits) begin
            coord = half[COORD_W-1:0];
        end else if (half[PROD_W-1]) begin
            coord = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            coord = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    logic [CNT_W:0]   x_steps;
    logic [CNT_W:0]   y_steps;
    logic [NUM_W-1:0] v0, v1, v2, v3, vm;
    logic [2*CNT_W+1:0] grid_total;
    logic [2*CNT_W-1:0] mid_offset;
    logic             is_vertex;
    logic             even;
    logic             left;

    // doubled index: even for grid vertices, odd for midpoints
    assign x_steps   = {item.col, item.kind == KIND_MID};
    assign y_steps   = {item.row, item.kind == KIND_MID};
    assign is_vertex = (item.kind == KIND_GRID) || (item.kind == KIND_MID);

    // quad corner numbers
    assign v0         = item.row_base + NUM_W'(item.col);
    assign v1         = v0 + 1'b1;
    assign v2         = v0 + NUM_W'(cfg.cols) + 1'b1;
    assign v3         = v2 + 1'b1;
    assign grid_total = ({1'b0, cfg.cols} + 1'b1) * ({1'b0, cfg.rows} + 1'b1);
    assign mid_offset = item.row * cfg.cols;
    assign vm         = NUM_W'(grid_total) + NUM_W'(mid_offset) + NUM_W'(item.col);

    // diagonal direction of this quad
    assign even = ~(item.col[0] ^ item.row[0]);
    assign left = (cfg.diag_mode == DIAG_LEFT) || (cfg.diag_mode > DIAG_CROSS) ||
                  ((cfg.diag_mode == DIAG_RL) && even) ||
                  ((cfg.diag_mode == DIAG_LR) && !even);

    always_comb begin
        result             = '0;
        result.kind        = item.kind;
        result.last        = item.last;
        if (item.kind != KIND_DONE) begin
            result.item_number = item.item_number;
        end
        if (is_vertex) begin
            result.x_coord = coord(cfg.x_start, cfg.x_spacing, x_steps);
            result.y_coord = coord(cfg.y_start, cfg.y_spacing, y_steps);
        end
        if (item.kind == KIND_TRI) begin
            if (cfg.diag_mode == DIAG_CROSS) begin
                result.corner_c = vm;
                case (item.sub)
                    2'd0: begin
                        result.corner_a = v0;
                        result.corner_b = v1;
                    end
                    2'd1: begin
                        result.corner_a = v0;
                        result.corner_b = v2;
                    end
                    2'd2: begin
                        result.corner_a = v1;
                        result.corner_b = v3;
                    end
                    default: begin
                        result.corner_a = v2;
                        result.corner_b = v3;
                    end
                endcase
            end else if (left) begin
                if (item.sub == 2'd0) begin
                    result.corner_a = v0;
                    result.corner_b = v1;
                    result.corner_c = v2;
                end else begin
                    result.corner_a = v1;
                    result.corner_b = v2;
                    result.corner_c = v3;
                end
            end else begin
                result.corner_a = v0;
                result.corner_c = v3;
                result.corner_b = (item.sub == 2'd0) ? v1 : v2;
            end
        end
    end

endmodule

// ----- sv/rectangle_triangle_mesh_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_triangle_mesh_generator
// Streams a structured triangle mesh of a rectangle: grid vertices, quad
// midpoints in crossed mode, then triangles, one result beat per request.
// Path: an accepted request goes through the sequencer register, then
//   the geometry stage into the output register that drives m_tvalid.
// Throughput: one request per cycle, limited only by m_tready.
// Reset (aresetn low, synchronous): pass restarts at vertex 0, registers
//   return to cols 1, rows 1, left diagonals, origin 0, spacings 1.0.
// ----------------------------------------------------------------------------
module rectangle_triangle_mesh_generator
    import rtmg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [0] restart, [7:1] zero
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // [21:0] item_number, [53:22] x_coord, [85:54] y_coord,
    // [107:86] corner_a, [129:108] corner_b, [151:130] corner_c
    output logic [151:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast,   // last triangle of the mesh
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [CNT_W-1:0]   cols_reg;
    logic [CNT_W-1:0]   rows_reg;
    logic [2:0]         diag_reg;
    logic [COORD_W-1:0] x_start_reg;
    logic [COORD_W-1:0] y_start_reg;
    logic [COORD_W-1:0] x_spacing_reg;
    logic [COORD_W-1:0] y_spacing_reg;
    reg_idx_t           reg_index;
    logic               cfg_write;
    cfg_t               cfg;

    logic               s_accept;
    logic               stage_advance;
    logic               out_advance;
    logic               item_valid;
    seq_item_t          item;
    out_item_t          result;
    logic               m_valid_reg;
    out_item_t          out_reg;

    // register write
    assign pready    = 1'b1;
    assign reg_index = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg      <= CNT_W'(1);
            rows_reg      <= CNT_W'(1);
            diag_reg      <= DIAG_LEFT;
            x_start_reg   <= '0;
            y_start_reg   <= '0;
            x_spacing_reg <= COORD_W'(65536);
            y_spacing_reg <= COORD_W'(65536);
        end else if (cfg_write) begin
            case (reg_index)
                REG_COLS:      cols_reg      <= pwdata[CNT_W-1:0];
                REG_ROWS:      rows_reg      <= pwdata[CNT_W-1:0];
                REG_DIAG:      diag_reg      <= pwdata[2:0];
                REG_X_START:   x_start_reg   <= pwdata;
                REG_Y_START:   y_start_reg   <= pwdata;
                REG_X_SPACING: x_spacing_reg <= pwdata;
                REG_Y_SPACING: y_spacing_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        case (reg_index)
            REG_COLS:      prdata = 32'(cols_reg);
            REG_ROWS:      prdata = 32'(rows_reg);
            REG_DIAG:      prdata = 32'(diag_reg);
            REG_X_START:   prdata = x_start_reg;
            REG_Y_START:   prdata = y_start_reg;
            REG_X_SPACING: prdata = x_spacing_reg;
            REG_Y_SPACING: prdata = y_spacing_reg;
            default:       prdata = '0;
        endcase
    end

    // counts clamped to 1..max
    always_comb begin
        cfg.cols = cols_reg;
        if (cols_reg == '0) begin
            cfg.cols = CNT_W'(1);
        end else if (cols_reg > CNT_W'(MAX_COLS)) begin
            cfg.cols = CNT_W'(MAX_COLS);
        end
        cfg.rows = rows_reg;
        if (rows_reg == '0) begin
            cfg.rows = CNT_W'(1);
        end else if (rows_reg > CNT_W'(MAX_ROWS)) begin
            cfg.rows = CNT_W'(MAX_ROWS);
        end
        cfg.diag_mode = diag_reg;
        cfg.x_start   = $signed(x_start_reg);
        cfg.y_start   = $signed(y_start_reg);
        cfg.x_spacing = $signed(x_spacing_reg);
        cfg.y_spacing = $signed(y_spacing_reg);
    end

    // pipeline flow control
    assign out_advance   = !m_valid_reg || m_tready;
    assign stage_advance = !item_valid || out_advance;
    assign s_tready      = stage_advance;
    assign s_accept      = s_tvalid && stage_advance;

    rtmg_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .req_valid     (s_accept),
        .req_restart   (s_tdata[0]),
        .stage_advance (stage_advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    rtmg_geom u_geom (
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_advance) begin
            m_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_advance && item_valid) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {out_reg.corner_c, out_reg.corner_b, out_reg.corner_a,
                       out_reg.y_coord, out_reg.x_coord, out_reg.item_number};

endmodule

// ----- dv/rtmg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmg_checker
// Watches the register port and both streams of the mesh generator. Keeps
// its own copy of the registers and of the pass walk (phase, quad and
// triangle counters, running vertex and triangle numbers), works out the
// beat each accepted request must produce, and compares every result beat
// field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module rtmg_checker
    import rtmg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,   // [0] restart, [7:1] zero
    input  logic         m_tvalid,
    input  logic         m_tready,
    // [21:0] item_number, [53:22] x_coord, [85:54] y_coord,
    // [107:86] corner_a, [129:108] corner_b, [151:130] corner_c
    input  logic [151:0] m_tdata,
    input  logic [1:0]   m_tuser,   // [1:0] kind
    input  logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           error_count,
    output int           pending_count
);

    localparam int unsigned NUM_MASK  = (1 << NUM_W) - 1;
    localparam longint      COORD_MAX = 2147483647;
    localparam longint      COORD_MIN = -COORD_MAX - 1;

    // register shadow
    logic [CNT_W-1:0]          cfg_cols;
    logic [CNT_W-1:0]          cfg_rows;
    logic [2:0]                cfg_diag;
    logic signed [COORD_W-1:0] cfg_x0;
    logic signed [COORD_W-1:0] cfg_y0;
    logic signed [COORD_W-1:0] cfg_dx;
    logic signed [COORD_W-1:0] cfg_dy;

    // walk through the pass
    phase_t      pass_phase;
    int unsigned col_idx;
    int unsigned row_idx;
    int unsigned tri_idx;
    int unsigned vert_num;
    int unsigned tri_num;
    int unsigned row_first;

    out_item_t   expected_q[$];
    out_item_t   want_item;

    function automatic int unsigned clamp_count(input logic [CNT_W-1:0] v,
                                                input int unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX[COORD_W-1:0];
        if (v < COORD_MIN)
            return COORD_MIN[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    function automatic void clear_walk();
        col_idx   = 0;
        row_idx   = 0;
        tri_idx   = 0;
        row_first = 0;
    endfunction

    function automatic void restart_walk();
        pass_phase = PH_GRID;
        clear_walk();
        vert_num = 0;
        tri_num  = 0;
    endfunction

    // beat produced by one request, advancing the walk
    function automatic out_item_t next_mesh_item(input logic restart);
        out_item_t   r;
        int unsigned qc;
        int unsigned qr;
        int unsigned per_quad;
        int unsigned v0;
        int unsigned v1;
        int unsigned v2;
        int unsigned v3;
        int unsigned vm;
        logic        crossed;
        logic        even;
        logic        use_left;
        r        = '0;
        qc       = clamp_count(cfg_cols, MAX_COLS);
        qr       = clamp_count(cfg_rows, MAX_ROWS);
        crossed  = (cfg_diag == DIAG_CROSS);
        per_quad = crossed ? 4 : 2;
        if (restart)
            restart_walk();

        // grid vertices, row-major
        if (pass_phase == PH_GRID) begin
            if (col_idx > qc) begin
                col_idx = 0;
                row_idx++;
            end
            if (row_idx > qr) begin
                pass_phase = crossed ? PH_MID : PH_TRI;
                clear_walk();
            end else begin
                r.kind        = KIND_GRID;
                r.item_number = vert_num[NUM_W-1:0];
                r.x_coord     = sat_coord(longint'(cfg_x0) +
                                          longint'(col_idx) * longint'(cfg_dx));
                r.y_coord     = sat_coord(longint'(cfg_y0) +
                                          longint'(row_idx) * longint'(cfg_dy));
                vert_num = (vert_num + 1) & NUM_MASK;
                col_idx++;
                if (col_idx > qc) begin
                    col_idx = 0;
                    row_idx++;
                end
                return r;
            end
        end

        // quad midpoints, crossed mode only; halving floors
        if (pass_phase == PH_MID) begin
            if (!crossed) begin
                pass_phase = PH_TRI;
                clear_walk();
            end else begin
                if (col_idx >= qc) begin
                    col_idx = 0;
                    row_idx++;
                end
                if (row_idx >= qr) begin
                    pass_phase = PH_TRI;
                    clear_walk();
                end else begin
                    r.kind        = KIND_MID;
                    r.item_number = vert_num[NUM_W-1:0];
                    r.x_coord     = sat_coord((2 * longint'(cfg_x0) +
                                    longint'(2 * col_idx + 1) * longint'(cfg_dx)) >>> 1);
                    r.y_coord     = sat_coord((2 * longint'(cfg_y0) +
                                    longint'(2 * row_idx + 1) * longint'(cfg_dy)) >>> 1);
                    vert_num = (vert_num + 1) & NUM_MASK;
                    col_idx++;
                    if (col_idx >= qc) begin
                        col_idx = 0;
                        row_idx++;
                    end
                    return r;
                end
            end
        end

        // triangles, quad by quad
        if (pass_phase == PH_TRI) begin
            if (tri_idx >= per_quad) begin
                tri_idx = 0;
                col_idx++;
            end
            if (col_idx >= qc) begin
                col_idx   = 0;
                row_idx++;
                row_first = (row_first + qc + 1) & NUM_MASK;
            end
            if (row_idx >= qr) begin
                pass_phase = PH_DONE;
            end else begin
                v0 = (row_first + col_idx) & NUM_MASK;
                v1 = (v0 + 1) & NUM_MASK;
                v2 = (v0 + qc + 1) & NUM_MASK;
                v3 = (v2 + 1) & NUM_MASK;
                vm = ((qc + 1) * (qr + 1) + row_idx * qc + col_idx) & NUM_MASK;
                if (crossed) begin
                    case (tri_idx)
                        0: begin
                            r.corner_a = v0[NUM_W-1:0];
                            r.corner_b = v1[NUM_W-1:0];
                        end
                        1: begin
                            r.corner_a = v0[NUM_W-1:0];
                            r.corner_b = v2[NUM_W-1:0];
                        end
                        2: begin
                            r.corner_a = v1[NUM_W-1:0];
                            r.corner_b = v3[NUM_W-1:0];
                        end
                        default: begin
                            r.corner_a = v2[NUM_W-1:0];
                            r.corner_b = v3[NUM_W-1:0];
                        end
                    endcase
                    r.corner_c = vm[NUM_W-1:0];
                end else begin
                    // checkerboard on row plus column; unknown modes go left
                    even     = ((col_idx + row_idx) & 1) == 0;
                    use_left = (cfg_diag == DIAG_LEFT) || (cfg_diag > DIAG_CROSS) ||
                               (cfg_diag == DIAG_RL && even) ||
                               (cfg_diag == DIAG_LR && !even);
                    if (use_left) begin
                        r.corner_a = (tri_idx == 0) ? v0[NUM_W-1:0] : v1[NUM_W-1:0];
                        r.corner_b = (tri_idx == 0) ? v1[NUM_W-1:0] : v2[NUM_W-1:0];
                        r.corner_c = (tri_idx == 0) ? v2[NUM_W-1:0] : v3[NUM_W-1:0];
                    end else begin
                        r.corner_a = v0[NUM_W-1:0];
                        r.corner_b = (tri_idx == 0) ? v1[NUM_W-1:0] : v2[NUM_W-1:0];
                        r.corner_c = v3[NUM_W-1:0];
                    end
                end
                r.kind        = KIND_TRI;
                r.item_number = tri_num[NUM_W-1:0];
                tri_num = (tri_num + 1) & NUM_MASK;
                tri_idx++;
                if (tri_idx >= per_quad) begin
                    tri_idx = 0;
                    col_idx++;
                    if (col_idx >= qc) begin
                        col_idx   = 0;
                        row_idx++;
                        row_first = (row_first + qc + 1) & NUM_MASK;
                        if (row_idx >= qr) begin
                            pass_phase = PH_DONE;
                            r.last     = 1'b1;
                        end
                    end
                end
                return r;
            end
        end

        // past the end of the pass
        r.kind = KIND_DONE;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // register shadow, prediction and comparison
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_cols = 1;
            cfg_rows = 1;
            cfg_diag = DIAG_LEFT;
            cfg_x0   = 0;
            cfg_y0   = 0;
            cfg_dx   = 32'h0001_0000;
            cfg_dy   = 32'h0001_0000;
            restart_walk();
            expected_q.delete();
            error_count   = 0;
            pending_count = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_COLS:      cfg_cols = pwdata[CNT_W-1:0];
                    REG_ROWS:      cfg_rows = pwdata[CNT_W-1:0];
                    REG_DIAG:      cfg_diag = pwdata[2:0];
                    REG_X_START:   cfg_x0   = pwdata;
                    REG_Y_START:   cfg_y0   = pwdata;
                    REG_X_SPACING: cfg_dx   = pwdata;
                    REG_Y_SPACING: cfg_dy   = pwdata;
                    default: ;
                endcase
            end

            // result beats, matched before this edge's request is queued
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with no request outstanding");
                    error_count++;
                end else begin
                    want_item = expected_q.pop_front();
                    check_field("kind",        want_item.kind,        m_tuser);
                    check_field("item_number", want_item.item_number, m_tdata[21:0]);
                    check_field("x_coord",     want_item.x_coord,     m_tdata[53:22]);
                    check_field("y_coord",     want_item.y_coord,     m_tdata[85:54]);
                    check_field("corner_a",    want_item.corner_a,    m_tdata[107:86]);
                    check_field("corner_b",    want_item.corner_b,    m_tdata[129:108]);
                    check_field("corner_c",    want_item.corner_c,    m_tdata[151:130]);
                    check_field("last",        want_item.last,        m_tlast);
                end
            end

            // request beats
            if (s_tvalid && s_tready)
                expected_q.push_back(next_mesh_item(s_tdata[0]));

            pending_count = expected_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the rectangle triangle mesh generator: a few directed passes
// over the corner cases (saturation, floored midpoints, clamped counts,
// unknown diagonal mode), then randomized configurations with full and
// partial passes, restarts mid-pass and register changes between passes.
// Both stream sides idle at random; the checker beside the block predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
    import rtmg_pkg::*;

    localparam int ITEM_TARGET     = 1450;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int IDLE_PCT        = 36;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int error_count;
    int pending_count;
    int quiet_cycles;
    int sent_items   = 0;
    bit no_idle      = 1'b0;
    bit hold_off_req = 1'b0;

    // register values last written, for sizing passes
    logic [31:0] cur_cols = 32'd1;
    logic [31:0] cur_rows = 32'd1;
    logic [31:0] cur_diag = 32'd0;

    rectangle_triangle_mesh_generator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rtmg_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random idling, one long hold-off on request
    initial begin
        int held;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles without any accepted beat or register access
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                     (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // one request beat, with a random gap in front
    task automatic send_req(input logic restart);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_tready);
        sent_items++;
        @(negedge aclk);
    endtask

    // stop sending until every result beat is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        repeat (3) @(negedge aclk);
    endtask

    // setup phase and access phase, then idle
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        case (idx)
            REG_COLS: cur_cols = val;
            REG_ROWS: cur_rows = val;
            REG_DIAG: cur_diag = val;
            default: ;
        endcase
    endtask

    // mostly tiny meshes, sometimes zero, the maximum or above it
    function automatic logic [31:0] pick_count(input int unsigned top);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 78)
            return $urandom_range(1, 4);
        if (r < 86)
            return $urandom_range(5, 10);
        if (r < 90)
            return 32'd0;
        if (r < 94)
            return top;
        if (r < 97)
            return 32'h7FF;
        // junk above the register width
        return ($urandom & 32'hFFFF_F800) | $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        if (r < 65)
            return $urandom;
        if (r < 75)
            return 32'h7FFF_FFFF;
        if (r < 85)
            return 32'h8000_0000;
        // a few units of the last place, odd and negative included
        return $urandom_range(0, 6) - 3;
    endfunction

    function automatic logic [31:0] pick_diag();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(DIAG_LEFT, DIAG_CROSS);
        if (r < 92)
            return $urandom_range(5, 7);
        return ($urandom & 32'hFFFF_FFF8) | $urandom_range(DIAG_LEFT, DIAG_CROSS);
    endfunction

    task automatic shuffle_config(input bit write_all);
        if (write_all || $urandom_range(0, 99) < 60)
            reg_write(REG_COLS, pick_count(MAX_COLS));
        if (write_all || $urandom_range(0, 99) < 60)
            reg_write(REG_ROWS, pick_count(MAX_ROWS));
        if (write_all || $urandom_range(0, 99) < 60)
            reg_write(REG_DIAG, pick_diag());
        if (write_all || $urandom_range(0, 99) < 40)
            reg_write(REG_X_START, pick_coord());
        if (write_all || $urandom_range(0, 99) < 40)
            reg_write(REG_Y_START, pick_coord());
        if (write_all || $urandom_range(0, 99) < 40)
            reg_write(REG_X_SPACING, pick_coord());
        if (write_all || $urandom_range(0, 99) < 40)
            reg_write(REG_Y_SPACING, pick_coord());
    endtask

    // requests for a whole pass plus a done beat or two; big meshes in part
    function automatic int pass_beats();
        int unsigned qc;
        int unsigned qr;
        int unsigned total;
        qc = (cur_cols[10:0] == 0) ? 1 :
             (cur_cols[10:0] > MAX_COLS) ? MAX_COLS : cur_cols[10:0];
        qr = (cur_rows[10:0] == 0) ? 1 :
             (cur_rows[10:0] > MAX_ROWS) ? MAX_ROWS : cur_rows[10:0];
        total = (qc + 1) * (qr + 1) + qc * qr * ((cur_diag[2:0] == DIAG_CROSS) ? 5 : 2);
        if (total > 150)
            return $urandom_range(5, 60);
        return total + $urandom_range(1, 2);
    endfunction

    initial begin
        int  i;
        int  n;
        int  phase_no;
        bit  fresh;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 5'd0;
        pwdata   = 32'd0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset configuration straight out of reset: one quad, left, then done
        for (i = 0; i < 8; i++)
            send_req(1'b0);

        // crossed quad with saturating x and floored negative midpoint y
        wait_drained();
        reg_write(REG_DIAG,      DIAG_CROSS);
        reg_write(REG_X_START,   32'h7FFF_0000);
        reg_write(REG_X_SPACING, 32'h7FFF_FFFF);
        reg_write(REG_Y_START,   32'hFFFF_FFFD);
        reg_write(REG_Y_SPACING, 32'hFFFF_FFFF);
        for (i = 0; i < 10; i++)
            send_req(i == 0);

        // zero and oversize counts, unknown diagonal, saturation low
        wait_drained();
        reg_write(REG_COLS,      32'd0);
        reg_write(REG_ROWS,      32'h7FF);
        reg_write(REG_DIAG,      32'd7);
        reg_write(REG_X_START,   32'h8000_0000);
        reg_write(REG_X_SPACING, 32'h8000_0000);
        reg_write(REG_Y_SPACING, 32'h7FFF_FFFF);
        for (i = 0; i < 5; i++)
            send_req(i == 0);

        // random passes, some continued across a register change
        phase_no = 0;
        while (sent_items < ITEM_TARGET) begin
            wait_drained();
            no_idle = (sent_items >= 600) && (sent_items < 900);
            shuffle_config(phase_no == 0);
            fresh = (phase_no == 0) || ($urandom_range(0, 99) < 80);
            n     = pass_beats();
            if (phase_no == 2) begin
                hold_off_req = 1'b1;
                if (n < 40)
                    n = 40;
            end
            for (i = 0; i < n; i++)
                send_req((i == 0 && fresh) || ($urandom_range(0, 99) < 2));
            phase_no++;
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- rectangle_triangle_mesh_generator.f -----
sv/rtmg_pkg.sv
sv/rtmg_seq.sv
sv/rtmg_geom.sv
sv/rectangle_triangle_mesh_generator.sv
dv/rtmg_checker.sv
dv/tb.sv
